/* rtl/core/apq_pkg.sv */
// Shared types and codes for the array minimum priority queue.
package apq_pkg;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] entry_value;
		logic signed [15:0] entry_priority;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] item_value;
		logic signed [15:0] item_priority;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] slot_value;
		logic signed [15:0] slot_prio;
	} slot_t;

	typedef struct packed {
		logic  ins;
		logic  rem;
		slot_t new_slot;
	} cell_ctl_t;

endpackage

/* rtl/core/apq_cell.sv */
// One queue cell: holds one entry, shifts in from its neighbors or takes a new entry.
module apq_cell (
	input  logic              clk,
	input  apq_pkg::cell_ctl_t ctl,
	input  logic              occ,
	input  logic              left_gt,
	input  apq_pkg::slot_t    left_slot,
	input  apq_pkg::slot_t    right_slot,
	output logic              gt,
	output apq_pkg::slot_t    slot
);

	apq_pkg::slot_t slot_q;
	apq_pkg::slot_t slot_nxt;

	// Ranks behind the new entry: empty, or strictly larger priority (ties stay ahead).
	assign gt = !occ || (slot_q.slot_prio > ctl.new_slot.slot_prio);

	always_comb begin
		slot_nxt = slot_q;
		if (ctl.ins && gt) begin
			slot_nxt = left_gt ? left_slot : ctl.new_slot;
		end else if (ctl.rem) begin
			slot_nxt = right_slot;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_nxt;
	end

	assign slot = slot_q;

endmodule

/* rtl/core/array_min_priority_queue.sv */
// Top level of the array minimum priority queue built as a sorted row of cells.
//
//   channel   direction  handshake            payload
//   request   in         start, busy          req  (mode, entry_value, entry_priority)
//   result    out        done (one cycle)     rsp  (status, item_value, item_priority)
//
// For each item, the accept edge latches the request, and the next edge updates the
// cell row and registers the result, which shows with done high for exactly one
// cycle. busy stays high until that edge, so the next item is accepted no sooner
// than the edge that ends the result strobe.
// Reset clears the fill count and the control flags; cell contents are left as is.
// The receiver cannot stall, so nothing ever waits on the result side.
module array_min_priority_queue #(
	parameter int DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  apq_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output apq_pkg::rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic               pend_q;
	apq_pkg::req_t      req_q;
	logic [CW-1:0]      count_q;
	logic               done_q;
	apq_pkg::rsp_t      rsp_q;
	apq_pkg::rsp_t      rsp_nxt;
	apq_pkg::cell_ctl_t ctl;

	logic           gt_w        [DEPTH];
	logic           occ_w       [DEPTH];
	logic           left_gt_w   [DEPTH];
	apq_pkg::slot_t slot_w      [DEPTH];
	apq_pkg::slot_t left_slot_w [DEPTH];
	apq_pkg::slot_t right_slot_w[DEPTH];

	logic accept;
	logic is_full;
	logic is_empty;

	assign accept   = start && !busy;
	assign busy     = pend_q;
	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);

	// Broadcast the pending operation to every cell; drop it when full or empty.
	assign ctl.ins      = pend_q && (req_q.mode == apq_pkg::MODE_INSERT) && !is_full;
	assign ctl.rem      = pend_q && (req_q.mode == apq_pkg::MODE_REMOVE) && !is_empty;
	assign ctl.new_slot = '{slot_value: req_q.entry_value, slot_prio: req_q.entry_priority};

	// Cells are kept sorted by priority, earlier arrivals first among ties,
	// so the head cell always holds the entry to remove.
	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			assign occ_w[g] = (CW'(g) < count_q);

			if (g == 0) begin : g_head
				assign left_gt_w[g]   = 1'b0;
				assign left_slot_w[g] = '0;
			end else begin : g_body
				assign left_gt_w[g]   = gt_w[g-1];
				assign left_slot_w[g] = slot_w[g-1];
			end

			if (g == DEPTH - 1) begin : g_tail
				assign right_slot_w[g] = slot_w[g];
			end else begin : g_next
				assign right_slot_w[g] = slot_w[g+1];
			end

			apq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.occ        (occ_w[g]),
				.left_gt    (left_gt_w[g]),
				.left_slot  (left_slot_w[g]),
				.right_slot (right_slot_w[g]),
				.gt         (gt_w[g]),
				.slot       (slot_w[g])
			);
		end
	endgenerate

	// Form the result from the state seen before the row updates.
	always_comb begin
		rsp_nxt.status        = apq_pkg::ST_DONE;
		rsp_nxt.item_value    = '0;
		rsp_nxt.item_priority = '0;
		if (req_q.mode == apq_pkg::MODE_INSERT) begin
			if (is_full) begin
				rsp_nxt.status = apq_pkg::ST_FULL;
			end
		end else begin
			if (is_empty) begin
				rsp_nxt.status = apq_pkg::ST_EMPTY;
			end else begin
				rsp_nxt.item_value    = slot_w[0].slot_value;
				rsp_nxt.item_priority = slot_w[0].slot_prio;
			end
		end
	end

	// Control state: pending flag, fill count, result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			pend_q <= accept;
			done_q <= pend_q;
			if (ctl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.rem) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Payload: hold the request while it works, capture the result with the strobe.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (pend_q) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a working cycle");

	a_one_work_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("fill count beyond depth");

	a_full_reported: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && (req_q.mode == apq_pkg::MODE_INSERT) && is_full)
		|=> (done && (rsp.status == apq_pkg::ST_FULL) && (count_q == FULL_CNT)))
		else $error("insert on a full queue not reported");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (slot_w[0].slot_prio <= slot_w[1].slot_prio))
		else $error("head cells out of priority order");
`endif

endmodule
